FILE: hdl/rwdm_pkg.sv
// Package for the register window with dirty map.
// Command codes, bus base address, default window size and payload types.
// No dependencies.
package rwdm_pkg;

	localparam logic [2:0] CMD_READ  = 3'd0;
	localparam logic [2:0] CMD_WRITE = 3'd1;
	localparam logic [2:0] CMD_TEST  = 3'd2;
	localparam logic [2:0] CMD_CLEAR = 3'd3;
	localparam logic [2:0] CMD_SET   = 3'd4;

	localparam logic [31:0] WINDOW_BASE = 32'hFFAA0000;
	localparam int WINDOW_BYTES_DEF = 256;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] bus_address;
		logic [7:0]  write_data;
		logic [7:0]  range_start;
		logic [8:0]  range_length;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       dirty_found;
		logic       out_of_window;
	} rsp_t;

	// Decoded access held in the first stage and handed to the dirty map.
	typedef struct packed {
		logic [2:0] cmd;
		logic       in_win;
		logic [7:0] start;
		logic [8:0] length;
	} op_t;

endpackage

FILE: hdl/rwdm_ram.sv
// Generic single-port RAM with registered read.
// Used for the byte store. No dependencies.
module rwdm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/rwdm_dirty.sv
// Dirty map: one flag per window byte, with range test, clear and set.
// Depends on rwdm_pkg.
module rwdm_dirty #(
	parameter int WINDOW_BYTES = rwdm_pkg::WINDOW_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  rwdm_pkg::op_t                   op,
	input  logic [$clog2(WINDOW_BYTES)-1:0] idx,
	output logic                            found
);
	import rwdm_pkg::*;

	localparam int IW = $clog2(WINDOW_BYTES);
	localparam int CW = (IW > 10) ? IW : 10;

	logic [WINDOW_BYTES-1:0] dirty_q;
	logic [WINDOW_BYTES-1:0] dirty_d;
	logic [WINDOW_BYTES-1:0] mask;
	logic [9:0]              range_end;

	assign range_end = 10'(op.start) + 10'(op.length);

	always_comb begin
		for (int i = 0; i < WINDOW_BYTES; i++) begin
			mask[i] = (CW'(i) >= CW'(op.start)) && (CW'(i) < CW'(range_end));
		end
	end

	assign found = (op.cmd == CMD_TEST) && |(dirty_q & mask);

	always_comb begin
		dirty_d = dirty_q;
		case (op.cmd)
			CMD_WRITE: begin
				for (int i = 0; i < WINDOW_BYTES; i++) begin
					if (op.in_win && idx == IW'(i)) begin
						dirty_d[i] = 1'b1;
					end
				end
			end
			CMD_CLEAR: dirty_d = dirty_q & ~mask;
			CMD_SET:   dirty_d = dirty_q | mask;
			default:   dirty_d = dirty_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= '0;
		end else if (en) begin
			dirty_q <= dirty_d;
		end
	end

endmodule

FILE: hdl/register_window_with_dirty_map_top.sv
// Top level of the register window with dirty map.
// Depends on rwdm_pkg, rwdm_ram and rwdm_dirty.
//
// channel | direction | handshake                | payload
// req     | in        | req_valid / req_ready    | req (rwdm_pkg::req_t)
// rsp     | out       | rsp_valid / rsp_ready    | rsp (rwdm_pkg::rsp_t)
//
// One transfer per cycle unless rsp stalls or the sweep runs; each request passes
// stage 1 (byte store read at the request edge, dirty map tested there) and then the
// result register. After reset the byte store is swept to zero, one byte a cycle,
// over all WINDOW_BYTES addresses; req_ready stays low until the sweep is over.
// A stalled rsp holds the result register and the stage behind it, then
// req_ready falls.
module register_window_with_dirty_map_top #(
	parameter int WINDOW_BYTES = rwdm_pkg::WINDOW_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  rwdm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output rwdm_pkg::rsp_t rsp
);
	import rwdm_pkg::*;

	localparam int IW = $clog2(WINDOW_BYTES);

	logic          clr_busy_q;
	logic [IW-1:0] clr_idx_q;

	logic          req_xfer;
	logic [31:0]   offset;
	logic          in_win;
	logic [IW-1:0] req_idx;

	logic          ram_we;
	logic [IW-1:0] ram_addr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;

	logic          valid_s1;
	op_t           op_s1;
	logic [IW-1:0] idx_s1;
	logic          adv_s1;
	logic          found_s1;

	logic          rsp_valid_q;
	rsp_t          rsp_q;

	assign offset  = req.bus_address - WINDOW_BASE;
	assign in_win  = offset < 32'(WINDOW_BYTES);
	assign req_idx = offset[IW-1:0];

	assign adv_s1    = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !clr_busy_q && (!valid_s1 || adv_s1);
	assign req_xfer  = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == IW'(WINDOW_BYTES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign ram_we    = clr_busy_q || (req_xfer && req.cmd == CMD_WRITE && in_win);
	assign ram_addr  = clr_busy_q ? clr_idx_q : req_idx;
	assign ram_wdata = clr_busy_q ? 8'd0 : req.write_data;

	rwdm_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_BYTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.re   (req_xfer),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_s1.cmd    <= req.cmd;
			op_s1.in_win <= in_win;
			op_s1.start  <= req.range_start;
			op_s1.length <= req.range_length;
			idx_s1       <= req_idx;
		end
	end

	rwdm_dirty #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_dirty (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (adv_s1),
		.op    (op_s1),
		.idx   (idx_s1),
		.found (found_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q.read_data     <= (op_s1.cmd == CMD_READ && op_s1.in_win) ? ram_rdata : 8'd0;
			rsp_q.dirty_found   <= found_s1;
			rsp_q.out_of_window <= (op_s1.cmd == CMD_READ || op_s1.cmd == CMD_WRITE)
				&& !op_s1.in_win;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: test/rwdm_checker.sv
// Checker for the register window with dirty map: watches both channels,
// keeps a shadow of the byte store and dirty map, and compares each result.
// Depends on rwdm_pkg.
module rwdm_checker #(
	parameter int WINDOW_BYTES = rwdm_pkg::WINDOW_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  rwdm_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  rwdm_pkg::rsp_t rsp,
	output int             fail_count,
	output int             outstanding
);
	import rwdm_pkg::*;

	logic [7:0]              shadow_bytes [WINDOW_BYTES];
	logic [WINDOW_BYTES-1:0] shadow_dirty;
	rsp_t                    pending_rsp [$];
	int                      errors;

	function automatic rsp_t window_access(req_t r);
		rsp_t        o;
		logic [31:0] offset;
		int          idx;
		o = '0;
		offset = r.bus_address - WINDOW_BASE;
		case (r.cmd)
		CMD_READ: begin
			if (offset < WINDOW_BYTES)
				o.read_data = shadow_bytes[offset];
			else
				o.out_of_window = 1'b1;
		end
		CMD_WRITE: begin
			if (offset < WINDOW_BYTES) begin
				shadow_bytes[offset] = r.write_data;
				shadow_dirty[offset] = 1'b1;
			end else begin
				o.out_of_window = 1'b1;
			end
		end
		CMD_TEST, CMD_CLEAR, CMD_SET: begin
			// bytes past the end of the store are ignored
			for (int i = 0; i < r.range_length; i++) begin
				idx = r.range_start + i;
				if (idx >= WINDOW_BYTES)
					break;
				if (r.cmd == CMD_TEST)
					o.dirty_found = o.dirty_found | shadow_dirty[idx];
				else
					shadow_dirty[idx] = (r.cmd == CMD_SET);
			end
		end
		default: ;
		endcase
		return o;
	endfunction

	task automatic flag(string what, logic [31:0] want, logic [31:0] got);
		errors++;
		if (errors <= 10)
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			pending_rsp.delete();
			shadow_dirty = '0;
			foreach (shadow_bytes[i])
				shadow_bytes[i] = '0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (pending_rsp.size() == 0) begin
					flag("unexpected result", '0, 32'(rsp));
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.read_data !== want.read_data)
						flag("read_data", 32'(want.read_data), 32'(rsp.read_data));
					if (rsp.dirty_found !== want.dirty_found)
						flag("dirty_found", 32'(want.dirty_found), 32'(rsp.dirty_found));
					if (rsp.out_of_window !== want.out_of_window)
						flag("out_of_window", 32'(want.out_of_window),
							32'(rsp.out_of_window));
				end
			end
			if (req_valid && req_ready)
				pending_rsp.push_back(window_access(req));
		end
		fail_count <= errors;
		outstanding <= pending_rsp.size();
	end

endmodule

FILE: test/tb_top.sv
// Testbench top for the register window with dirty map: clock, reset,
// directed and random accesses with random idling, watchdog and verdict.
// Depends on rwdm_pkg, register_window_with_dirty_map_top and rwdm_checker.
module tb_top;
	import rwdm_pkg::*;

	localparam int WINDOW_BYTES = WINDOW_BYTES_DEF;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 1200;
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	int   fail_count;
	int   outstanding;
	int   idle_cycles = 0;
	int   stall_left = 0;
	bit   calm;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	register_window_with_dirty_map_top #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	rwdm_checker #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			rsp_ready <= 1'b1;
			if (!calm && $urandom_range(0, 99) < 20)
				stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic req_t access(logic [2:0] c, logic [31:0] a, logic [7:0] d,
			logic [7:0] s, logic [8:0] l);
		req_t r;
		r.cmd = c;
		r.bus_address = a;
		r.write_data = d;
		r.range_start = s;
		r.range_length = l;
		return r;
	endfunction

	function automatic req_t random_access();
		req_t r;
		int   roll;
		int   len_roll;
		r = access(CMD_READ, 32'($urandom), 8'($urandom), 8'($urandom), 9'($urandom));
		roll = $urandom_range(0, 99);
		len_roll = $urandom_range(0, 99);
		if (len_roll < 70)
			r.range_length = 9'($urandom_range(0, 12));
		else if (len_roll < 90)
			r.range_length = 9'($urandom_range(13, 64));
		if (roll < 60) begin
			r.cmd = (roll < 30) ? CMD_READ : CMD_WRITE;
			r.bus_address = WINDOW_BASE + $urandom_range(0, WINDOW_BYTES - 1);
		end else if (roll < 85) begin
			case ($urandom_range(0, 4))
			0, 1: r.cmd = CMD_TEST;
			2: r.cmd = CMD_CLEAR;
			default: r.cmd = CMD_SET;
			endcase
		end else if (roll < 97) begin
			r.cmd = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
			case ($urandom_range(0, 2))
			0: r.bus_address = WINDOW_BASE - 1 - $urandom_range(0, 15);
			1: r.bus_address = WINDOW_BASE + WINDOW_BYTES + $urandom_range(0, 15);
			default: ;
			endcase
		end else begin
			r.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		end
		return r;
	endfunction

	task automatic send_access(input req_t item);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_ready !== 1'b1);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		calm = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_access(access(CMD_READ, WINDOW_BASE, 8'h00, 8'h00, 9'd0));
		send_access(access(CMD_WRITE, WINDOW_BASE, 8'hFF, 8'hFF, 9'd511));
		send_access(access(CMD_WRITE, WINDOW_BASE + WINDOW_BYTES - 1, 8'hA5, 8'h00, 9'd0));
		send_access(access(CMD_READ, WINDOW_BASE, 8'h00, 8'h00, 9'd0));
		send_access(access(CMD_READ, WINDOW_BASE + WINDOW_BYTES - 1, 8'h00, 8'h00, 9'd0));
		// just below the base, just past the end, and both ends of the bus
		send_access(access(CMD_READ, WINDOW_BASE - 1, 8'h00, 8'h00, 9'd0));
		send_access(access(CMD_READ, WINDOW_BASE + WINDOW_BYTES, 8'h00, 8'h00, 9'd0));
		send_access(access(CMD_READ, 32'hFFFF_FFFF, 8'h00, 8'h00, 9'd0));
		send_access(access(CMD_READ, 32'h0000_0000, 8'h00, 8'h00, 9'd0));
		send_access(access(CMD_WRITE, WINDOW_BASE + WINDOW_BYTES, 8'h5A, 8'h00, 9'd0));
		send_access(access(CMD_WRITE, 32'hFFFF_FFFF, 8'hFF, 8'h00, 9'd0));
		send_access(access(CMD_TEST, 32'h0, 8'h00, 8'h00, 9'd0));
		send_access(access(CMD_TEST, 32'h0, 8'h00, 8'h00, 9'd1));
		send_access(access(CMD_TEST, 32'h0, 8'h00, 8'h01, 9'd254));
		send_access(access(CMD_TEST, 32'h0, 8'h00, 8'hFF, 9'd511));
		send_access(access(CMD_CLEAR, 32'h0, 8'h00, 8'hFF, 9'd1));
		send_access(access(CMD_TEST, 32'h0, 8'h00, 8'hFF, 9'd1));
		send_access(access(CMD_SET, 32'h0, 8'h00, 8'h80, 9'd256));
		send_access(access(CMD_TEST, 32'h0, 8'h00, 8'hC8, 9'd1));
		send_access(access(CMD_CLEAR, 32'h0, 8'h00, 8'h00, 9'd511));
		send_access(access(CMD_SET, 32'h0, 8'h00, 8'h00, 9'd0));
		send_access(access(CMD_TEST, 32'h0, 8'h00, 8'h00, 9'd256));
		send_access(access(CMD_SPARE_LO, WINDOW_BASE, 8'hFF, 8'h00, 9'd511));
		send_access(access(3'(CMD_SPARE_LO + 1), 32'hFFFF_FFFF, 8'h00, 8'hFF, 9'd256));
		send_access(access(CMD_SPARE_HI, WINDOW_BASE + 1, 8'h3C, 8'h10, 9'd16));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (n == RANDOM_ITEMS / 2)
				drain();
			send_access(random_access());
		end

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: register_window_with_dirty_map_top.f
hdl/rwdm_pkg.sv
hdl/rwdm_ram.sv
hdl/rwdm_dirty.sv
hdl/register_window_with_dirty_map_top.sv
test/rwdm_checker.sv
test/tb_top.sv
